@@ sv/hhft_pkg.sv @@
`default_nettype none

package hhft_pkg;

  localparam int MAX_FIELDS = 1024;
  localparam int POS_BITS   = 16;
  localparam int FC_W       = $clog2(MAX_FIELDS + 1);
  localparam int LEN_W      = 16;
  localparam int NUM_W      = 10;
  localparam int OUT_POS_W  = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_URI     = 3'd1;
  localparam logic [2:0] KIND_VERSION = 3'd2;
  localparam logic [2:0] KIND_KEY     = 3'd3;
  localparam logic [2:0] KIND_VALUE   = 3'd4;
  localparam logic [2:0] KIND_STATUS  = 3'd5;

  localparam logic [2:0] STAT_RUN      = 3'd0;
  localparam logic [2:0] STAT_EOH      = 3'd1;
  localparam logic [2:0] STAT_BAD_HDR  = 3'd2;
  localparam logic [2:0] STAT_BAD_REQ  = 3'd3;
  localparam logic [2:0] STAT_TOO_MANY = 3'd4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [2:0]           kind;
    logic [NUM_W-1:0]     num;
    logic [OUT_POS_W-1:0] start;
    logic [LEN_W-1:0]     len;
    logic [2:0]           status;
    logic                 last;
  } result_t;

  typedef struct packed {
    result_t [1:0] r;
    logic [1:0]    n;
  } rbuf_t;

  function automatic rbuf_t put(rbuf_t b, result_t x);
    rbuf_t o;
    o = b;
    if (b.n == 2'd0) begin
      o.r[0] = x;
    end else if (b.n == 2'd1) begin
      o.r[1] = x;
    end
    if (b.n != 2'd2) begin
      o.n = b.n + 2'd1;
    end
    return o;
  endfunction

  function automatic result_t mk_result(logic [2:0] kind, logic [NUM_W-1:0] num,
                                        logic [OUT_POS_W-1:0] start, logic [LEN_W-1:0] len);
    result_t x;
    x.kind   = kind;
    x.num    = num;
    x.start  = start;
    x.len    = len;
    x.status = STAT_RUN;
    x.last   = 1'b0;
    return x;
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(logic [LEN_W-1:0] v);
    return (v == {LEN_W{1'b1}}) ? v : v + LEN_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ sv/hhft_if.sv @@
`default_nettype none

interface hhft_in_if import hhft_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  logic       chunk_last;

  modport source (output valid, output data_byte, output restart, output chunk_last,
                  input ready);
  modport sink (input valid, input data_byte, input restart, input chunk_last,
                output ready);
endinterface

interface hhft_out_if import hhft_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           field_kind;
  logic [NUM_W-1:0]     field_number;
  logic [OUT_POS_W-1:0] start_pos;
  logic [LEN_W-1:0]     field_length;
  logic [2:0]           status;
  logic                 last;

  modport source (output valid, output field_kind, output field_number, output start_pos,
                  output field_length, output status, output last, input ready);
  modport sink (input valid, input field_kind, input field_number, input start_pos,
                input field_length, input status, input last, output ready);
endinterface

`default_nettype wire

@@ sv/hhft_parser.sv @@
`default_nettype none

module hhft_parser import hhft_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  hhft_in_if.sink          head,
  input  wire logic [QCNT_W-1:0] fill,
  output rbuf_t            push
);

  localparam logic [1:0] GAP_FIELD = 2'd0;
  localparam logic [1:0] GAP_SEP   = 2'd1;
  localparam logic [1:0] GAP_LINE  = 2'd2;
  localparam logic [1:0] GAP_FOLD  = 2'd3;

  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic [1:0]          gap;
    logic                rdone;
    logic [FC_W-1:0]     fc;
    logic [POS_BITS-1:0] cstart;
    logic [LEN_W-1:0]    clen;
    logic                inws;
    logic [LEN_W-1:0]    las;
    logic                unone;
    logic [LEN_W-1:0]    uend;
    logic [POS_BITS-1:0] vstart;
    logic [LEN_W-1:0]    lav;
    logic [2:0]          sstat;
    logic                pcr;
  } pstate_t;

  localparam pstate_t RESET_STATE = '{pos: '0, gap: GAP_FIELD, rdone: 1'b0, fc: '0,
                                      cstart: '0, clen: '0, inws: 1'b0, las: '0,
                                      unone: 1'b1, uend: '0, vstart: '0, lav: '0,
                                      sstat: STAT_RUN, pcr: 1'b0};

  function automatic rbuf_t pending(pstate_t s, rbuf_t b);
    rbuf_t            o;
    logic [LEN_W-1:0] vlen;
    logic [FC_W-1:0]  num;
    o = b;
    vlen = (s.clen > s.lav) ? s.clen - s.lav : '0;
    num = (s.fc != '0) ? s.fc - FC_W'(1) : '0;
    if (!s.rdone) begin
      if (s.unone) begin
        o = put(o, mk_result(KIND_URI, NUM_W'(1), OUT_POS_W'(s.cstart), s.clen));
      end else begin
        o = put(o, mk_result(KIND_URI, NUM_W'(1), OUT_POS_W'(s.cstart), s.uend));
        o = put(o, mk_result(KIND_VERSION, NUM_W'(2), OUT_POS_W'(s.vstart), vlen));
      end
    end else begin
      o = put(o, mk_result(KIND_VALUE, NUM_W'(num), OUT_POS_W'(s.cstart), s.clen));
    end
    return o;
  endfunction

  function automatic pstate_t open_field(pstate_t s, logic [POS_BITS-1:0] p);
    pstate_t o;
    o = s;
    o.cstart = p;
    o.clen = '0;
    o.inws = 1'b0;
    o.las = '0;
    return o;
  endfunction

  pstate_t st;
  pstate_t st_next;
  rbuf_t   rb;
  logic    stg_valid;
  logic [7:0] stg_byte;
  logic    stg_restart;
  logic    proceed;

  assign proceed = stg_valid && (fill <= QCNT_W'(QDEPTH - 2));
  assign head.ready = !stg_valid || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (head.ready) begin
      stg_valid <= head.valid;
    end
    if (head.valid && head.ready) begin
      stg_byte <= head.data_byte;
      stg_restart <= head.restart;
    end
  end

  always_comb begin
    pstate_t          s;
    logic [POS_BITS-1:0] p;
    logic             cr_before;
    logic             ws;
    logic             stop;
    logic [LEN_W-1:0] trimmed;
    logic [7:0]       b;
    s = stg_restart ? RESET_STATE : st;
    rb = '0;
    p = s.pos;
    s.pos = p + POS_BITS'(1);
    b = stg_byte;
    cr_before = s.pcr;
    ws = (b == CH_SPACE) || (b == CH_TAB);
    stop = 1'b0;
    trimmed = '0;
    if (s.sstat == STAT_RUN) begin
      s.pcr = (b == CH_CR);
      if (s.gap != GAP_FIELD) begin
        stop = 1'b1;
        if (b == CH_LF) begin
          if (s.gap == GAP_LINE || s.gap == GAP_FOLD) begin
            rb = pending(s, rb);
            s.sstat = STAT_EOH;
          end else begin
            s.sstat = STAT_BAD_HDR;
            rb = put(rb, mk_result(KIND_STATUS, '0, '0, '0));
          end
        end else if (b == CH_CR) begin
          stop = 1'b1;
        end else if (ws) begin
          if (s.gap == GAP_LINE) begin
            s.gap = GAP_FOLD;
          end
        end else begin
          stop = 1'b0;
          unique case (s.gap)
            GAP_SEP: begin
              if (!s.rdone) begin
                s.fc = FC_W'(1);
                s = open_field(s, p);
                s.unone = 1'b1;
              end else if (s.fc >= FC_W'(MAX_FIELDS)) begin
                s.sstat = STAT_TOO_MANY;
                rb = put(rb, mk_result(KIND_STATUS, '0, '0, '0));
                stop = 1'b1;
              end else begin
                s.fc = s.fc + FC_W'(1);
                s = open_field(s, p);
              end
            end
            GAP_LINE: begin
              rb = pending(s, rb);
              if (!s.rdone) begin
                s.rdone = 1'b1;
                s.fc = '0;
              end
              if (b == CH_COLON) begin
                s.sstat = STAT_BAD_HDR;
                stop = 1'b1;
              end else if (s.fc >= FC_W'(MAX_FIELDS)) begin
                s.sstat = STAT_TOO_MANY;
                stop = 1'b1;
              end else begin
                s.fc = s.fc + FC_W'(1);
                s = open_field(s, p);
              end
            end
            default: begin
              trimmed = s.clen;
              s.clen = sat_inc(s.clen);
              s.inws = 1'b0;
              if (!s.rdone) begin
                s.unone = 1'b0;
                s.uend = trimmed;
                s.vstart = p;
                s.lav = s.clen;
              end
            end
          endcase
          if (!stop) begin
            s.gap = GAP_FIELD;
          end
        end
      end
      if (!stop) begin
        if (!s.rdone && s.fc == '0) begin
          if (b == CH_SPACE) begin
            rb = put(rb, mk_result(KIND_METHOD, '0, OUT_POS_W'(s.cstart), s.clen));
            s.gap = GAP_SEP;
            s.unone = 1'b1;
          end else if (b == CH_CR || b == CH_LF) begin
            s.sstat = STAT_BAD_REQ;
            rb = put(rb, mk_result(KIND_STATUS, '0, '0, '0));
          end else begin
            s.clen = sat_inc(s.clen);
          end
        end else if (s.rdone && s.fc[0]) begin
          s.clen = s.clen;
          if (b == CH_COLON) begin
            rb = put(rb, mk_result(KIND_KEY, NUM_W'(s.fc - FC_W'(1)),
                                   OUT_POS_W'(s.cstart), s.clen));
            s.gap = GAP_SEP;
          end else if (b == CH_LF) begin
            s.sstat = STAT_BAD_HDR;
            rb = put(rb, mk_result(KIND_STATUS, '0, '0, '0));
          end else begin
            s.clen = sat_inc(s.clen);
          end
        end else if (b == CH_LF) begin
          if (s.inws) begin
            trimmed = s.las;
          end else if (cr_before && s.clen != '0) begin
            trimmed = s.clen - LEN_W'(1);
          end else begin
            trimmed = s.clen;
          end
          s.clen = trimmed;
          s.inws = 1'b0;
          s.gap = GAP_LINE;
        end else begin
          if (ws) begin
            if (!s.inws) begin
              s.inws = 1'b1;
              s.las = s.clen;
            end
          end else if (b != CH_CR && s.inws) begin
            s.inws = 1'b0;
            if (!s.rdone) begin
              s.unone = 1'b0;
              s.uend = s.las;
              s.vstart = p;
              s.lav = s.clen;
            end
          end
          s.clen = sat_inc(s.clen);
        end
      end
    end
    rb.r[0].status = s.sstat;
    rb.r[1].status = s.sstat;
    rb.r[0].last = (rb.n == 2'd1);
    rb.r[1].last = 1'b1;
    st_next = s;
  end

  always_comb begin
    push = rb;
    if (!proceed) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= RESET_STATE;
    end else if (proceed) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/hhft_result_queue.sv @@
`default_nettype none

module hhft_result_queue import hhft_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rbuf_t             push,
  hhft_out_if.source             token,
  output logic [QCNT_W-1:0]      fill
);

  result_t            mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               pop;
  result_t            head_entry;

  assign pop = token.valid && token.ready;
  assign fill = count;
  assign head_entry = mem[rd_ptr];

  assign token.valid        = (count != '0);
  assign token.field_kind   = head_entry.kind;
  assign token.field_number = head_entry.num;
  assign token.start_pos    = head_entry.start;
  assign token.field_length = head_entry.len;
  assign token.status       = head_entry.status;
  assign token.last         = head_entry.last;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r[0];
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

@@ sv/http_header_field_tokenizer.sv @@
// Tokenizer for the head of an HTTP request, fed one byte per transfer.
// The head channel carries data_byte, restart and chunk_last; restart set on
// a byte clears all parse state, and that byte then sits at position zero.
// chunk_last is carried along but does not affect parsing.
// The token channel carries one field per transfer: kind, number, start
// position, length, the status after the byte, and last on the final field
// caused by that byte. A byte causes zero, one or two fields.
// A byte accepted on the head channel is held in the input register, parsed
// from there into the result queue, and its fields are offered on the token
// channel from the queue head. The head channel takes one byte per cycle
// while the queue has room; the token channel sends one field per cycle
// while the receiver is ready. A four-entry result queue decouples the
// channels, and a byte is parsed only when two queue entries are free.
// When the receiver stalls, the queue fills and head ready drops after one
// byte is held in the input register; no field is lost.
// Reset clears the input register, the queue and all parse state.
// After end of headers or an error, bytes are accepted and give no fields
// until a byte with restart arrives.
`default_nettype none

module http_header_field_tokenizer import hhft_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  hhft_in_if.sink  head,
  hhft_out_if.source token
);

  rbuf_t              push;
  logic [QCNT_W-1:0]  fill;

  hhft_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .fill (fill),
    .push (push)
  );

  hhft_result_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .token (token),
    .fill  (fill)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    token.valid && token.field_kind == KIND_STATUS |-> token.status != STAT_RUN && token.last)
    else $error("status-only field without a final status");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    token.valid |-> token.field_kind <= KIND_STATUS && token.status <= STAT_TOO_MANY)
    else $error("field kind or status out of range");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    fill > QCNT_W'(QDEPTH - 2) && $past(head.valid && head.ready) && !rst && !$past(rst)
    |-> !head.ready)
    else $error("byte taken while the queue lacks room");

endmodule

`default_nettype wire
